// ===== design/flvdmx_pkg.sv =====
package flvdmx_pkg;

  localparam int FRAME_LEN_BITS = 32;

  localparam logic [FRAME_LEN_BITS-1:0] FRAME_LEN_MAX = '1;

  // packet kinds
  localparam logic [1:0] PKT_OTHER = 2'd0;
  localparam logic [1:0] PKT_VIDEO = 2'd1;
  localparam logic [1:0] PKT_AUDIO = 2'd2;

  // unit kinds
  localparam logic [2:0] UNIT_SPS        = 3'd0;
  localparam logic [2:0] UNIT_PPS        = 3'd1;
  localparam logic [2:0] UNIT_IDR        = 3'd2;
  localparam logic [2:0] UNIT_VIDEO      = 3'd3;
  localparam logic [2:0] UNIT_AUD_INFO_M = 3'd4;
  localparam logic [2:0] UNIT_AUD_DATA_M = 3'd6;

  localparam logic [4:0] COUNT_MASK    = 5'h1F;
  localparam logic [7:0] AVC_KEY_LEAD  = 8'h17;
  localparam logic [7:0] AAC_MONO_LEAD = 8'hAE;
  localparam logic [7:0] SEQ_HDR_MARK  = 8'h00;

  // body byte indexes
  localparam logic [3:0] SEQ_SKIP_END  = 4'd9;
  localparam logic [3:0] FR_SKIP_END   = 4'd4;
  localparam logic [3:0] FR_LEN_END    = 4'd8;
  localparam logic [3:0] AUD_START_IDX = 4'd2;
  localparam logic [3:0] INDEX_MAX     = 4'd15;

  typedef enum logic [14:0] {
    PH_IDLE     = 15'b000000000000001,
    PH_BYTE1    = 15'b000000000000010,
    PH_SEQ_SKIP = 15'b000000000000100,
    PH_COUNT    = 15'b000000000001000,
    PH_LEN_HI   = 15'b000000000010000,
    PH_LEN_LO   = 15'b000000000100000,
    PH_PS_FIRST = 15'b000000001000000,
    PH_PS_REST  = 15'b000000010000000,
    PH_FR_SKIP  = 15'b000000100000000,
    PH_FR_LEN   = 15'b000001000000000,
    PH_FR_FIRST = 15'b000010000000000,
    PH_FR_REST  = 15'b000100000000000,
    PH_AUD_INFO = 15'b001000000000000,
    PH_AUD_DATA = 15'b010000000000000,
    PH_DROP     = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    logic [1:0] packet_kind;
    logic [7:0] body_byte;
    logic       packet_first;
    logic       packet_last;
  } item_t;

  typedef struct packed {
    logic [2:0] unit_kind;
    logic [7:0] payload_byte;
    logic       unit_first;
    logic       unit_last;
    logic       truncated;
  } result_t;

endpackage

// ===== design/flv_avc_aac_tag_demux_core.sv =====
// Path: the input register and then the result register lie between an input
// transaction and the result transaction it causes. Throughput: one body byte per
// cycle while the result register is not held by a stalled m_tready.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to idle, waiting for a packet start.
module flv_avc_aac_tag_demux_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // body_byte
  input  logic [2:0] s_tuser,   // packet_kind[1:0], packet_first[2]
  input  logic       s_tlast,   // packet_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // payload_byte
  output logic [4:0] m_tuser,   // unit_kind[2:0], unit_first[3], truncated[4]
  output logic       m_tlast    // unit_last
);

  logic                item_valid;
  flvdmx_pkg::item_t   item;
  logic                consume;
  logic                space;
  logic                emit;
  flvdmx_pkg::result_t res;

  assign consume = item_valid && space;

  flvdmx_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  flvdmx_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .consume (consume),
    .item    (item),
    .emit    (emit),
    .res     (res)
  );

  flvdmx_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (consume && emit),
    .res      (res),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !consume)
    else $error("result register overwritten while stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> s_tready)
    else $error("empty input register not ready");

  a_consume_needs_item: assert property (@(posedge clk) disable iff (rst)
    consume |-> item_valid)
    else $error("parser advanced without an item");

endmodule

// ===== design/flvdmx_in_stage.sv =====
module flvdmx_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,  // body_byte
  input  logic [2:0]         s_tuser,  // packet_kind[1:0], packet_first[2]
  input  logic               s_tlast,  // packet_last
  input  logic               consume,
  output logic               item_valid,
  output flvdmx_pkg::item_t  item
);

  assign s_tready = !item_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.packet_kind  <= s_tuser[1:0];
      item.body_byte    <= s_tdata;
      item.packet_first <= s_tuser[2];
      item.packet_last  <= s_tlast;
    end
  end

endmodule

// ===== design/flvdmx_parser.sv =====
module flvdmx_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                consume,
  input  flvdmx_pkg::item_t   item,
  output logic                emit,
  output flvdmx_pkg::result_t res
);

  flvdmx_pkg::phase_t parse_phase, parse_phase_next;
  logic [3:0]  header_index, header_index_next;
  logic [7:0]  leading_byte, leading_byte_next;
  logic [1:0]  latched_kind, latched_kind_next;
  logic [4:0]  units_left, units_left_next;
  logic        in_pps_list, in_pps_list_next;
  logic [flvdmx_pkg::FRAME_LEN_BITS-1:0] bytes_left, bytes_left_next;
  logic [23:0] length_partial, length_partial_next;

  logic [flvdmx_pkg::FRAME_LEN_BITS-1:0] bytes_dec;
  logic [31:0] full_len;
  logic        len_sat;
  logic        done;
  logic [4:0]  units_dec;
  logic [7:0]  b;
  logic        last;

  assign b         = item.body_byte;
  assign last      = item.packet_last;
  assign bytes_dec = bytes_left - flvdmx_pkg::FRAME_LEN_BITS'(1);
  assign done      = (bytes_dec == '0);
  assign units_dec = units_left - 5'd1;
  assign full_len  = {length_partial, b};
  assign len_sat   = (flvdmx_pkg::FRAME_LEN_BITS < 32) &&
                     ((full_len >> flvdmx_pkg::FRAME_LEN_BITS) != 32'd0);

  always_comb begin
    parse_phase_next    = parse_phase;
    header_index_next   = header_index;
    leading_byte_next   = leading_byte;
    latched_kind_next   = latched_kind;
    units_left_next     = units_left;
    in_pps_list_next    = in_pps_list;
    bytes_left_next     = bytes_left;
    length_partial_next = length_partial;
    emit                = 1'b0;
    res                 = '0;
    res.payload_byte    = b;

    if (item.packet_first) begin
      latched_kind_next   = item.packet_kind;
      leading_byte_next   = b;
      header_index_next   = 4'd1;
      units_left_next     = '0;
      in_pps_list_next    = 1'b0;
      bytes_left_next     = '0;
      length_partial_next = '0;
      if (last) begin
        parse_phase_next = flvdmx_pkg::PH_IDLE;
      end else if (item.packet_kind == flvdmx_pkg::PKT_VIDEO ||
                   item.packet_kind == flvdmx_pkg::PKT_AUDIO) begin
        parse_phase_next = flvdmx_pkg::PH_BYTE1;
      end else begin
        parse_phase_next = flvdmx_pkg::PH_DROP;
      end
    end else if (parse_phase != flvdmx_pkg::PH_IDLE) begin
      case (parse_phase)
        flvdmx_pkg::PH_BYTE1: begin
          if (latched_kind == flvdmx_pkg::PKT_VIDEO) begin
            parse_phase_next = (b == flvdmx_pkg::SEQ_HDR_MARK) ?
                               flvdmx_pkg::PH_SEQ_SKIP : flvdmx_pkg::PH_FR_SKIP;
          end else begin
            parse_phase_next = (b == flvdmx_pkg::SEQ_HDR_MARK) ?
                               flvdmx_pkg::PH_AUD_INFO : flvdmx_pkg::PH_AUD_DATA;
          end
        end
        flvdmx_pkg::PH_SEQ_SKIP: begin
          if (header_index >= flvdmx_pkg::SEQ_SKIP_END) begin
            in_pps_list_next = 1'b0;
            parse_phase_next = flvdmx_pkg::PH_COUNT;
          end
        end
        flvdmx_pkg::PH_COUNT: begin
          units_left_next = b[4:0] & flvdmx_pkg::COUNT_MASK;
          if ((b[4:0] & flvdmx_pkg::COUNT_MASK) == 5'd0) begin
            in_pps_list_next = 1'b1;
            parse_phase_next = in_pps_list ? flvdmx_pkg::PH_DROP : flvdmx_pkg::PH_COUNT;
          end else begin
            parse_phase_next = flvdmx_pkg::PH_LEN_HI;
          end
        end
        flvdmx_pkg::PH_LEN_HI: begin
          length_partial_next = {16'd0, b};
          parse_phase_next    = flvdmx_pkg::PH_LEN_LO;
        end
        flvdmx_pkg::PH_LEN_LO: begin
          bytes_left_next = flvdmx_pkg::FRAME_LEN_BITS'({length_partial[7:0], b});
          if ({length_partial[7:0], b} == 16'd0) begin
            units_left_next = units_dec;
            if (units_dec == 5'd0) begin
              in_pps_list_next = 1'b1;
              parse_phase_next = in_pps_list ? flvdmx_pkg::PH_DROP : flvdmx_pkg::PH_COUNT;
            end else begin
              parse_phase_next = flvdmx_pkg::PH_LEN_HI;
            end
          end else begin
            parse_phase_next = flvdmx_pkg::PH_PS_FIRST;
          end
        end
        flvdmx_pkg::PH_PS_FIRST, flvdmx_pkg::PH_PS_REST: begin
          emit            = 1'b1;
          res.unit_kind   = in_pps_list ? flvdmx_pkg::UNIT_PPS : flvdmx_pkg::UNIT_SPS;
          res.unit_first  = (parse_phase == flvdmx_pkg::PH_PS_FIRST);
          res.unit_last   = done || last;
          res.truncated   = !done && last;
          bytes_left_next = bytes_dec;
          if (done) begin
            units_left_next = units_dec;
            if (units_dec == 5'd0) begin
              in_pps_list_next = 1'b1;
              parse_phase_next = in_pps_list ? flvdmx_pkg::PH_DROP : flvdmx_pkg::PH_COUNT;
            end else begin
              parse_phase_next = flvdmx_pkg::PH_LEN_HI;
            end
          end else begin
            parse_phase_next = flvdmx_pkg::PH_PS_REST;
          end
        end
        flvdmx_pkg::PH_FR_SKIP: begin
          if (header_index >= flvdmx_pkg::FR_SKIP_END) begin
            length_partial_next = '0;
            parse_phase_next    = flvdmx_pkg::PH_FR_LEN;
          end
        end
        flvdmx_pkg::PH_FR_LEN: begin
          if (header_index < flvdmx_pkg::FR_LEN_END) begin
            length_partial_next = {length_partial[15:0], b};
          end else begin
            bytes_left_next  = len_sat ? flvdmx_pkg::FRAME_LEN_MAX :
                               full_len[flvdmx_pkg::FRAME_LEN_BITS-1:0];
            parse_phase_next = (full_len == 32'd0) ? flvdmx_pkg::PH_DROP :
                               flvdmx_pkg::PH_FR_FIRST;
          end
        end
        flvdmx_pkg::PH_FR_FIRST, flvdmx_pkg::PH_FR_REST: begin
          emit             = 1'b1;
          res.unit_kind    = (leading_byte == flvdmx_pkg::AVC_KEY_LEAD) ?
                             flvdmx_pkg::UNIT_IDR : flvdmx_pkg::UNIT_VIDEO;
          res.unit_first   = (parse_phase == flvdmx_pkg::PH_FR_FIRST);
          res.unit_last    = done || last;
          res.truncated    = !done && last;
          bytes_left_next  = bytes_dec;
          parse_phase_next = done ? flvdmx_pkg::PH_DROP : flvdmx_pkg::PH_FR_REST;
        end
        flvdmx_pkg::PH_AUD_INFO, flvdmx_pkg::PH_AUD_DATA: begin
          emit          = 1'b1;
          res.unit_kind = ((parse_phase == flvdmx_pkg::PH_AUD_INFO) ?
                           flvdmx_pkg::UNIT_AUD_INFO_M : flvdmx_pkg::UNIT_AUD_DATA_M) |
                          {2'b00, leading_byte != flvdmx_pkg::AAC_MONO_LEAD};
          res.unit_first = (header_index == flvdmx_pkg::AUD_START_IDX);
          res.unit_last  = last;
          res.truncated  = 1'b0;
        end
        default: begin
        end
      endcase

      if (header_index < flvdmx_pkg::INDEX_MAX) begin
        header_index_next = header_index + 4'd1;
      end
      if (last) begin
        parse_phase_next = flvdmx_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= flvdmx_pkg::PH_IDLE;
      header_index   <= '0;
      leading_byte   <= '0;
      latched_kind   <= '0;
      units_left     <= '0;
      in_pps_list    <= 1'b0;
      bytes_left     <= '0;
      length_partial <= '0;
    end else if (consume) begin
      parse_phase    <= parse_phase_next;
      header_index   <= header_index_next;
      leading_byte   <= leading_byte_next;
      latched_kind   <= latched_kind_next;
      units_left     <= units_left_next;
      in_pps_list    <= in_pps_list_next;
      bytes_left     <= bytes_left_next;
      length_partial <= length_partial_next;
    end
  end

  a_trunc_closes: assert property (@(posedge clk) disable iff (rst)
    emit && res.truncated |-> res.unit_last)
    else $error("truncated byte without unit end");

  a_no_emit_on_first: assert property (@(posedge clk) disable iff (rst)
    emit |-> !item.packet_first)
    else $error("result on packet start byte");

  a_restart_index: assert property (@(posedge clk) disable iff (rst)
    consume && item.packet_first |=> header_index == 4'd1)
    else $error("packet start did not restart byte index");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    consume && item.packet_last |=> parse_phase == flvdmx_pkg::PH_IDLE)
    else $error("parser not idle after packet end");

endmodule

// ===== design/flvdmx_out_stage.sv =====
module flvdmx_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  flvdmx_pkg::result_t res,
  output logic                space,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,  // payload_byte
  output logic [4:0]          m_tuser,  // unit_kind[2:0], unit_first[3], truncated[4]
  output logic                m_tlast   // unit_last
);

  assign space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= res.payload_byte;
      m_tuser <= {res.truncated, res.unit_first, res.unit_kind};
      m_tlast <= res.unit_last;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

  localparam int LIMIT        = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 900;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [1:0] PKT_RESERVED = 2'd3;

  // how a stimulus row gets its expectation
  localparam logic [1:0] ROW_PREDICT = 2'd0;
  localparam logic [1:0] ROW_NONE    = 2'd1;
  localparam logic [1:0] ROW_UNIT    = 2'd2;

  typedef struct packed {
    flvdmx_pkg::item_t   it;
    logic [1:0]          mode;
    flvdmx_pkg::result_t exp;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;   // body_byte
  logic [2:0] s_tuser = '0;   // packet_kind[1:0], packet_first[2]
  logic       s_tlast = 1'b0; // packet_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;        // payload_byte
  logic [4:0] m_tuser;        // unit_kind[2:0], unit_first[3], truncated[4]
  logic       m_tlast;        // unit_last

  always #2 clk = ~clk;

  flv_avc_aac_tag_demux_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // parser mirror
  flvdmx_pkg::phase_t p_phase = flvdmx_pkg::PH_IDLE;
  logic [3:0]  p_index   = '0;
  logic [7:0]  p_lead    = '0;
  logic [1:0]  p_kind    = '0;
  logic [4:0]  p_units   = '0;
  logic        p_pps     = 1'b0;
  logic [31:0] p_left    = '0;
  logic [23:0] p_partial = '0;

  flvdmx_pkg::result_t payload_due[$];
  logic [1:0]          row_mode = ROW_PREDICT;
  flvdmx_pkg::result_t row_exp  = '0;

  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned cycles = 0;
  int unsigned body_bytes = 0;
  int unsigned n_audio = 0, n_frame = 0, n_seq = 0, n_other = 0, n_broken = 0;
  int unsigned burst_left = 0;
  int unsigned hold_seq = 0, hold_seen = 0, hold_left = 0, rx_cyc = 0;

  logic [7:0] pkt[$];
  row_t       rows[$];

  task automatic close_list();
    if (!p_pps) begin
      p_pps   = 1'b1;
      p_phase = flvdmx_pkg::PH_COUNT;
    end else begin
      p_phase = flvdmx_pkg::PH_DROP;
    end
  endtask

  task automatic next_unit();
    p_units = p_units - 5'd1;
    if (p_units == 0) close_list();
    else p_phase = flvdmx_pkg::PH_LEN_HI;
  endtask

  task automatic parse_body_byte(input flvdmx_pkg::item_t it, output bit emit,
                                 output flvdmx_pkg::result_t r);
    logic [3:0]  idx;
    logic [31:0] full;
    logic        done;
    logic [2:0]  k;
    emit = 1'b0;
    r    = '0;
    idx  = p_index;
    if (it.packet_first) begin
      p_kind    = it.packet_kind;
      p_lead    = it.body_byte;
      p_index   = 4'd1;
      p_units   = '0;
      p_pps     = 1'b0;
      p_left    = '0;
      p_partial = '0;
      p_phase   = (it.packet_kind == flvdmx_pkg::PKT_VIDEO ||
                   it.packet_kind == flvdmx_pkg::PKT_AUDIO) ?
                  flvdmx_pkg::PH_BYTE1 : flvdmx_pkg::PH_DROP;
      if (it.packet_last) p_phase = flvdmx_pkg::PH_IDLE;
    end else if (p_phase != flvdmx_pkg::PH_IDLE) begin
      case (p_phase)
        flvdmx_pkg::PH_BYTE1: begin
          if (p_kind == flvdmx_pkg::PKT_VIDEO)
            p_phase = (it.body_byte == flvdmx_pkg::SEQ_HDR_MARK) ?
                      flvdmx_pkg::PH_SEQ_SKIP : flvdmx_pkg::PH_FR_SKIP;
          else
            p_phase = (it.body_byte == flvdmx_pkg::SEQ_HDR_MARK) ?
                      flvdmx_pkg::PH_AUD_INFO : flvdmx_pkg::PH_AUD_DATA;
        end
        flvdmx_pkg::PH_SEQ_SKIP: begin
          if (idx >= flvdmx_pkg::SEQ_SKIP_END) begin
            p_pps   = 1'b0;
            p_phase = flvdmx_pkg::PH_COUNT;
          end
        end
        flvdmx_pkg::PH_COUNT: begin
          p_units = it.body_byte[4:0] & flvdmx_pkg::COUNT_MASK;
          if (p_units == 0) close_list();
          else p_phase = flvdmx_pkg::PH_LEN_HI;
        end
        flvdmx_pkg::PH_LEN_HI: begin
          p_partial = {16'd0, it.body_byte};
          p_phase   = flvdmx_pkg::PH_LEN_LO;
        end
        flvdmx_pkg::PH_LEN_LO: begin
          p_left = {16'd0, p_partial[7:0], it.body_byte};
          if (p_left == 0) next_unit();
          else p_phase = flvdmx_pkg::PH_PS_FIRST;
        end
        flvdmx_pkg::PH_PS_FIRST, flvdmx_pkg::PH_PS_REST: begin
          p_left = p_left - 1;
          done   = (p_left == 0);
          r      = {p_pps ? flvdmx_pkg::UNIT_PPS : flvdmx_pkg::UNIT_SPS, it.body_byte,
                    p_phase == flvdmx_pkg::PH_PS_FIRST,
                    done || it.packet_last, !done && it.packet_last};
          emit   = 1'b1;
          if (done) next_unit();
          else p_phase = flvdmx_pkg::PH_PS_REST;
        end
        flvdmx_pkg::PH_FR_SKIP: begin
          if (idx >= flvdmx_pkg::FR_SKIP_END) begin
            p_partial = '0;
            p_phase   = flvdmx_pkg::PH_FR_LEN;
          end
        end
        flvdmx_pkg::PH_FR_LEN: begin
          if (idx < flvdmx_pkg::FR_LEN_END) begin
            p_partial = {p_partial[15:0], it.body_byte};
          end else begin
            full = {p_partial, it.body_byte};
            if (full > flvdmx_pkg::FRAME_LEN_MAX) full = flvdmx_pkg::FRAME_LEN_MAX;
            p_left  = full;
            p_phase = (p_left == 0) ? flvdmx_pkg::PH_DROP : flvdmx_pkg::PH_FR_FIRST;
          end
        end
        flvdmx_pkg::PH_FR_FIRST, flvdmx_pkg::PH_FR_REST: begin
          p_left = p_left - 1;
          done   = (p_left == 0);
          r      = {(p_lead == flvdmx_pkg::AVC_KEY_LEAD) ?
                    flvdmx_pkg::UNIT_IDR : flvdmx_pkg::UNIT_VIDEO, it.body_byte,
                    p_phase == flvdmx_pkg::PH_FR_FIRST, done || it.packet_last,
                    !done && it.packet_last};
          emit    = 1'b1;
          p_phase = done ? flvdmx_pkg::PH_DROP : flvdmx_pkg::PH_FR_REST;
        end
        flvdmx_pkg::PH_AUD_INFO, flvdmx_pkg::PH_AUD_DATA: begin
          k = (p_phase == flvdmx_pkg::PH_AUD_INFO) ?
              flvdmx_pkg::UNIT_AUD_INFO_M : flvdmx_pkg::UNIT_AUD_DATA_M;
          if (p_lead != flvdmx_pkg::AAC_MONO_LEAD) k = k + 3'd1;
          r    = {k, it.body_byte, idx == flvdmx_pkg::AUD_START_IDX, it.packet_last,
                  1'b0};
          emit = 1'b1;
        end
        default: ;
      endcase
      if (p_index < flvdmx_pkg::INDEX_MAX) p_index = p_index + 4'd1;
      if (it.packet_last) p_phase = flvdmx_pkg::PH_IDLE;
    end
  endtask

  task automatic note_failure(input string what, input flvdmx_pkg::result_t want,
                              input flvdmx_pkg::result_t got);
    errors++;
    if (errors <= 10)
      $display("%s: exp kind %0d byte %02h f %0b l %0b t %0b | got kind %0d byte %02h f %0b l %0b t %0b",
               what, want.unit_kind, want.payload_byte, want.unit_first, want.unit_last,
               want.truncated, got.unit_kind, got.payload_byte, got.unit_first,
               got.unit_last, got.truncated);
  endtask

  always @(posedge clk) begin : monitor
    flvdmx_pkg::item_t   seen;
    flvdmx_pkg::result_t want;
    flvdmx_pkg::result_t got;
    bit                  emit;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen = {s_tuser[1:0], s_tdata, s_tuser[2], s_tlast};
        parse_body_byte(seen, emit, want);
        if (row_mode == ROW_UNIT) payload_due.push_back(row_exp);
        else if (row_mode == ROW_PREDICT && emit) payload_due.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser[2:0], m_tdata, m_tuser[3], m_tlast, m_tuser[4]};
        checked++;
        if (payload_due.size() == 0) begin
          note_failure("unexpected transaction", '0, got);
        end else begin
          want = payload_due.pop_front();
          if (got !== want) note_failure("mismatch", want, got);
        end
      end
    end
  end

  // receiver: rotating stall patterns plus requested long hold-offs
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      case (rx_cyc[8:6])
        3'd0, 3'd1: m_tready <= 1'b1;
        3'd2, 3'd3: m_tready <= 1'($urandom_range(0, 1));
        3'd4, 3'd5: m_tready <= (rx_cyc % 5) != 0;
        default:    m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               payload_due.size());
      $display("flv_avc_aac_tag_demux_core regression: fail");
      $finish;
    end
  end

  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
                   $urandom_range(1, 16);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic offer(input flvdmx_pkg::item_t it, input logic [1:0] mode,
                       input flvdmx_pkg::result_t exp);
    s_tvalid <= 1'b1;
    s_tdata  <= it.body_byte;
    s_tuser  <= {it.packet_first, it.packet_kind};
    s_tlast  <= it.packet_last;
    row_mode <= mode;
    row_exp  <= exp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic add_row(input logic [1:0] k, input logic [7:0] b, input logic f,
                         input logic l, input logic [1:0] m,
                         input flvdmx_pkg::result_t e);
    row_t r;
    r.it   = {k, b, f, l};
    r.mode = m;
    r.exp  = e;
    rows.push_back(r);
  endtask

  task automatic build_audio(input int unsigned len);
    pkt.delete();
    pkt.push_back(($urandom_range(0, 1) != 0) ? flvdmx_pkg::AAC_MONO_LEAD : 8'($urandom));
    if (len > 1)
      pkt.push_back(($urandom_range(0, 2) == 0) ? flvdmx_pkg::SEQ_HDR_MARK : 8'($urandom));
    while (pkt.size() < len) pkt.push_back(8'($urandom));
  endtask

  task automatic send_packet(input logic [1:0] kind, input bit keep_last);
    flvdmx_pkg::item_t it;
    for (int i = 0; i < pkt.size(); i++) begin
      it.packet_kind  = kind;
      it.body_byte    = pkt[i];
      it.packet_first = (i == 0);
      it.packet_last  = keep_last && (i == pkt.size() - 1);
      pace();
      offer(it, ROW_PREDICT, '0);
      body_bytes++;
    end
  endtask

  initial begin
    logic [1:0]        kind;
    logic [31:0]       flen;
    int unsigned       sel, cnt, ulen, nbytes, cut;
    bit                keep_last, held, paused;
    flvdmx_pkg::item_t it;
    held   = 0;
    paused = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: stray byte, a sequence header cut short in its PPS, short audio, one-byte other
    add_row(PKT_RESERVED, 8'hFF, 1'b0, 1'b1, ROW_NONE, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, flvdmx_pkg::AVC_KEY_LEAD, 1'b1, 1'b0, ROW_PREDICT, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, flvdmx_pkg::SEQ_HDR_MARK, 1'b0, 1'b0, ROW_PREDICT, '0);
    repeat (8) add_row(flvdmx_pkg::PKT_VIDEO, 8'hFF, 1'b0, 1'b0, ROW_PREDICT, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, 8'hE2, 1'b0, 1'b0, ROW_PREDICT, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, 8'h00, 1'b0, 1'b0, ROW_PREDICT, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, 8'h00, 1'b0, 1'b0, ROW_PREDICT, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, 8'h00, 1'b0, 1'b0, ROW_PREDICT, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, 8'h01, 1'b0, 1'b0, ROW_PREDICT, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, 8'h67, 1'b0, 1'b0, ROW_UNIT,
            {flvdmx_pkg::UNIT_SPS, 8'h67, 1'b1, 1'b1, 1'b0});
    add_row(flvdmx_pkg::PKT_VIDEO, 8'h21, 1'b0, 1'b0, ROW_PREDICT, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, 8'h00, 1'b0, 1'b0, ROW_PREDICT, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, 8'h05, 1'b0, 1'b0, ROW_PREDICT, '0);
    add_row(flvdmx_pkg::PKT_VIDEO, 8'h68, 1'b0, 1'b1, ROW_UNIT,
            {flvdmx_pkg::UNIT_PPS, 8'h68, 1'b1, 1'b1, 1'b1});
    add_row(flvdmx_pkg::PKT_AUDIO, flvdmx_pkg::AAC_MONO_LEAD, 1'b1, 1'b0, ROW_NONE, '0);
    add_row(flvdmx_pkg::PKT_AUDIO, flvdmx_pkg::SEQ_HDR_MARK, 1'b0, 1'b1, ROW_NONE, '0);
    add_row(flvdmx_pkg::PKT_OTHER, 8'h00, 1'b1, 1'b1, ROW_NONE, '0);
    foreach (rows[i]) begin
      pace();
      offer(rows[i].it, rows[i].mode, rows[i].exp);
    end

    while (body_bytes < RANDOM_BYTES) begin
      if (!held && body_bytes >= 300) begin
        held = 1;
        hold_seq <= hold_seq + 1;
        build_audio(40);
        burst_left = 200;
        n_audio++;
        send_packet(flvdmx_pkg::PKT_AUDIO, 1'b1);
      end
      if (!paused && body_bytes >= 600) begin
        paused = 1;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (payload_due.size() != 0);
        burst_left = 0;
      end
      sel = $urandom_range(0, 99);
      keep_last = 1'b1;
      if (sel >= 90) begin
        repeat ($urandom_range(1, 3)) begin
          it = {2'($urandom), 8'($urandom), 1'b0, 1'($urandom_range(0, 1))};
          pace();
          offer(it, ROW_PREDICT, '0);
        end
        continue;
      end
      if (sel < 30) begin
        kind = flvdmx_pkg::PKT_AUDIO;
        n_audio++;
        build_audio(($urandom_range(0, 9) < 7) ? $urandom_range(3, 16) : $urandom_range(1, 3));
      end else if (sel < 55) begin
        kind = flvdmx_pkg::PKT_VIDEO;
        n_frame++;
        pkt.delete();
        pkt.push_back(($urandom_range(0, 1) != 0) ? flvdmx_pkg::AVC_KEY_LEAD : 8'($urandom));
        pkt.push_back(8'($urandom_range(1, 255)));
        repeat (3) pkt.push_back(8'($urandom));
        case ($urandom_range(0, 9))
          0:       flen = 32'd0;
          1:       flen = 32'hFFFF_FFFF;
          2:       flen = $urandom;
          default: flen = $urandom_range(1, 10);
        endcase
        for (int i = 3; i >= 0; i--) pkt.push_back(flen[8*i +: 8]);
        nbytes = (flen > 12) ? $urandom_range(1, 12) : flen + $urandom_range(0, 2);
        repeat (nbytes) pkt.push_back(8'($urandom));
      end else if (sel < 80) begin
        kind = flvdmx_pkg::PKT_VIDEO;
        n_seq++;
        pkt.delete();
        pkt.push_back(8'($urandom));
        pkt.push_back(flvdmx_pkg::SEQ_HDR_MARK);
        repeat (8) pkt.push_back(8'($urandom));
        for (int l = 0; l < 2; l++) begin
          cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 31) : $urandom_range(0, 3);
          pkt.push_back({3'($urandom), 5'(cnt)});
          repeat (cnt) begin
            if ($urandom_range(0, 39) == 0) ulen = $urandom_range(256, 270);
            else if ($urandom_range(0, 5) == 0) ulen = 0;
            else ulen = $urandom_range(1, 6);
            pkt.push_back(8'(ulen >> 8));
            pkt.push_back(8'(ulen));
            repeat (ulen) pkt.push_back(8'($urandom));
          end
        end
        repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom));
      end else begin
        kind = ($urandom_range(0, 1) != 0) ? flvdmx_pkg::PKT_OTHER : PKT_RESERVED;
        n_other++;
        build_audio($urandom_range(1, 6));
      end
      if ($urandom_range(0, 99) < 12) begin
        n_broken++;
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) pkt.delete(pkt.size() - 1);
        keep_last = ($urandom_range(0, 1) != 0);
      end
      send_packet(kind, keep_last);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (payload_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += payload_due.size();

    $display("%0d packet bytes sent: %0d audio, %0d frame, %0d sequence header, %0d other",
             body_bytes, n_audio, n_frame, n_seq, n_other);
    $display("%0d cut or unterminated packets, %0d payload transactions checked, %0d errors",
             n_broken, checked, errors);
    if (errors == 0) begin
      $display("flv_avc_aac_tag_demux_core regression: pass");
    end else begin
      $display("flv_avc_aac_tag_demux_core regression: fail");
    end
    $finish;
  end

endmodule
